// File: sv/ksr_pkg.sv
package ksr_pkg;

  localparam int DEPTH_DEFAULT    = 16;
  localparam int KEY_BITS_DEFAULT = 16;

  localparam int CFG_W    = 5;
  localparam int STATUS_W = 2;
  localparam int ABOVE_W  = 4;
  localparam int FILL_W   = 5;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd10;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

  localparam logic MODE_PUSH   = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef struct packed {
    logic shift;
    logic push;
  } cell_ctrl_t;

endpackage

// File: sv/ksr_in_if.sv
interface ksr_in_if #(
  parameter int KEY_BITS = 16
);
  logic                valid;
  logic                ready;
  logic                mode;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, mode, key, input ready);
  modport sink   (input valid, mode, key, output ready);
endinterface

// File: sv/ksr_out_if.sv
interface ksr_out_if;
  import ksr_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ABOVE_W-1:0]  entries_above;
  logic [FILL_W-1:0]   fill_count;

  modport source (output valid, status, entries_above, fill_count, input ready);
  modport sink   (input valid, status, entries_above, fill_count, output ready);
endinterface

// File: sv/ksr_cell.sv
module ksr_cell #(
  parameter int KEY_BITS = 16
) (
  input  logic                clk,
  input  ksr_pkg::cell_ctrl_t ctrl,
  input  logic [KEY_BITS-1:0] key,
  input  logic                occupied,
  input  logic                push_sel,
  input  logic [KEY_BITS-1:0] upper,
  input  logic                below_in,
  output logic [KEY_BITS-1:0] entry,
  output logic                hit,
  output logic                below_out
);
  import ksr_pkg::*;

  assign hit       = occupied && (entry == key);
  assign below_out = below_in || hit;

  // on remove, every cell at or above the hit takes its upper neighbour
  always_ff @(posedge clk) begin
    if (ctrl.shift && below_out) begin
      entry <= upper;
    end else if (ctrl.push && push_sel) begin
      entry <= key;
    end
  end
endmodule

// File: sv/keyed_stack_with_remove_core.sv
// channel  | dir | fields                              | handshake
// items    | in  | mode, key                           | valid/ready
// results  | out | status, entries_above, fill_count   | valid/ready
// cfg      | in  | cfg_data (capacity limit)           | cfg_we, no stall
//
// Each word is accepted, then evaluated: the cell row compares the key in parallel
// and shifts or loads in place; no new word is accepted until then.
// Evaluation waits while the result register still holds an untaken word.
// Synchronous reset empties the stack and sets the limit to 10; no clearing pass.
module keyed_stack_with_remove_core #(
  parameter int STACK_DEPTH = ksr_pkg::DEPTH_DEFAULT,
  parameter int KEY_BITS    = ksr_pkg::KEY_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [ksr_pkg::CFG_W-1:0] cfg_data,
  ksr_in_if.sink                    items,
  ksr_out_if.source                 results
);
  import ksr_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]    cap;
  logic                busy;
  logic                op_mode;
  logic [KEY_BITS-1:0] op_key;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;

  logic                eval;
  cell_ctrl_t          ctrl;
  logic [STACK_DEPTH-1:0] hit;
  logic [STACK_DEPTH:0]   below;
  logic [KEY_BITS-1:0] entry [STACK_DEPTH];
  logic [IDX_W-1:0]    hit_idx;
  logic                found;
  logic                full;
  logic [STATUS_W-1:0] status_next;
  logic [CNT_W-1:0]    above_wide;

  assign items.ready = !busy;
  assign eval        = busy && (!results.valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_we) begin
      cap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (items.valid && items.ready) begin
      busy <= 1'b1;
    end else if (eval) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      op_mode <= items.mode;
      op_key  <= items.key;
    end
  end

  assign below[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      logic [KEY_BITS-1:0] upper;
      if (gi == STACK_DEPTH - 1) begin : g_top
        assign upper = '0;
      end else begin : g_mid
        assign upper = entry[gi+1];
      end
      ksr_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .key       (op_key),
        .occupied  (CNT_W'(gi) < count),
        .push_sel  (count == CNT_W'(gi)),
        .upper     (upper),
        .below_in  (below[gi]),
        .entry     (entry[gi]),
        .hit       (hit[gi]),
        .below_out (below[gi+1])
      );
    end
  endgenerate

  // keys are unique in the store, so at most one cell hits
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (hit[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign found = below[STACK_DEPTH];
  assign full  = (LIM_W'(count) >= LIM_W'(STACK_DEPTH)) || (LIM_W'(count) >= LIM_W'(cap));

  assign ctrl.shift = eval && (op_mode == MODE_REMOVE) && found;
  assign ctrl.push  = eval && (op_mode == MODE_PUSH) && !full && !found;

  assign above_wide = count - CNT_W'(1) - CNT_W'(hit_idx);

  always_comb begin
    count_next  = count;
    status_next = ST_DONE;
    if (op_mode == MODE_PUSH) begin
      if (full) begin
        status_next = ST_FULL;
      end else if (found) begin
        status_next = ST_DUP;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (found) begin
        count_next = count - CNT_W'(1);
      end else begin
        status_next = ST_MISSING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (eval) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (eval) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval) begin
      results.status        <= status_next;
      results.entries_above <= ((op_mode == MODE_REMOVE) && found) ?
                               ABOVE_W'(above_wide) : '0;
      results.fill_count    <= FILL_W'(count_next);
    end
  end
endmodule

// File: sv/ksr_checker.sv
module ksr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ksr_pkg::STATUS_W-1:0] status,
  input logic [ksr_pkg::ABOVE_W-1:0]  entries_above
);
  import ksr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_above_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DONE) |-> entries_above == '0)
    else $error("entries_above set on a failed operation");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after an accepted word");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");
endmodule

bind keyed_stack_with_remove_core ksr_checker u_ksr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (items.valid),
  .in_ready      (items.ready),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .status        (results.status),
  .entries_above (results.entries_above)
);
